[src/eacw_pkg.sv]
package eacw_pkg;

  localparam int ColumnBits = 16;
  localparam int CfgIdxBits = 2;

  localparam logic [CfgIdxBits-1:0] CFG_CJK_AMB  = 2'd0;
  localparam logic [CfgIdxBits-1:0] CFG_TAB_DYN  = 2'd1;
  localparam logic [CfgIdxBits-1:0] CFG_TAB_SIZE = 2'd2;

  typedef enum logic [2:0] {
    CLS_ONE, CLS_TWO, CLS_AMB, CLS_ZERO, CLS_BS, CLS_TAB, CLS_BAD
  } cls_t;

  typedef struct packed {
    logic [20:0]        code_point;
    logic               first_of_string;
    logic signed [15:0] start_column;
    logic               last_of_string;
  } in_item_t;

  typedef struct packed {
    logic signed [7:0]  char_width;
    logic signed [15:0] cursor_column;
    logic signed [15:0] string_width;
    logic               invalid_char;
    logic               end_of_string;
  } out_item_t;

  // classified item handed from front to back
  typedef struct packed {
    cls_t               cls;
    logic               first;
    logic signed [15:0] start_column;
    logic               last;
  } cls_item_t;

  localparam int NumSpans = 164;

  localparam logic [1:0] SP_ONE = 2'd0;
  localparam logic [1:0] SP_TWO = 2'd1;
  localparam logic [1:0] SP_AMB = 2'd2;
  localparam logic [1:0] SP_NONE = 2'd3;

  localparam logic [33:0] SPANS [NumSpans] = '{
    {16'h0020,16'h007E,SP_ONE},{16'h00A1,16'h00A1,SP_AMB},{16'h00A2,16'h00A3,SP_ONE},
    {16'h00A4,16'h00A4,SP_AMB},{16'h00A5,16'h00A6,SP_ONE},{16'h00A7,16'h00A8,SP_AMB},
    {16'h00AA,16'h00AA,SP_AMB},{16'h00AC,16'h00AC,SP_ONE},{16'h00AD,16'h00AD,SP_AMB},
    {16'h00AF,16'h00AF,SP_ONE},{16'h00B0,16'h00B4,SP_AMB},{16'h00B6,16'h00BA,SP_AMB},
    {16'h00BC,16'h00BF,SP_AMB},{16'h00C6,16'h00C6,SP_AMB},{16'h00D0,16'h00D0,SP_AMB},
    {16'h00D7,16'h00D8,SP_AMB},{16'h00DE,16'h00E1,SP_AMB},{16'h00E6,16'h00E6,SP_AMB},
    {16'h00E8,16'h00EA,SP_AMB},{16'h00EC,16'h00ED,SP_AMB},{16'h00F0,16'h00F0,SP_AMB},
    {16'h00F2,16'h00F3,SP_AMB},{16'h00F7,16'h00FA,SP_AMB},{16'h00FC,16'h00FC,SP_AMB},
    {16'h00FE,16'h00FE,SP_AMB},{16'h0101,16'h0101,SP_AMB},{16'h0111,16'h0111,SP_AMB},
    {16'h0113,16'h0113,SP_AMB},{16'h011B,16'h011B,SP_AMB},{16'h0126,16'h0127,SP_AMB},
    {16'h012B,16'h012B,SP_AMB},{16'h0131,16'h0133,SP_AMB},{16'h0138,16'h0138,SP_AMB},
    {16'h013F,16'h0142,SP_AMB},{16'h0144,16'h0144,SP_AMB},{16'h0148,16'h014A,SP_AMB},
    {16'h014D,16'h014D,SP_AMB},{16'h0152,16'h0153,SP_AMB},{16'h0166,16'h0167,SP_AMB},
    {16'h016B,16'h016B,SP_AMB},{16'h01CE,16'h01CE,SP_AMB},{16'h01D0,16'h01D0,SP_AMB},
    {16'h01D2,16'h01D2,SP_AMB},{16'h01D4,16'h01D4,SP_AMB},{16'h01D6,16'h01D6,SP_AMB},
    {16'h01D8,16'h01D8,SP_AMB},{16'h01DA,16'h01DA,SP_AMB},{16'h01DC,16'h01DC,SP_AMB},
    {16'h0251,16'h0251,SP_AMB},{16'h0261,16'h0261,SP_AMB},{16'h02C7,16'h02C7,SP_AMB},
    {16'h02C9,16'h02CB,SP_AMB},{16'h02CD,16'h02CD,SP_AMB},{16'h02D0,16'h02D0,SP_AMB},
    {16'h02D8,16'h02DB,SP_AMB},{16'h02DD,16'h02DD,SP_AMB},{16'h0300,16'h0362,SP_AMB},
    {16'h0391,16'h03A9,SP_AMB},{16'h03B1,16'h03C1,SP_AMB},{16'h03C3,16'h03C9,SP_AMB},
    {16'h0401,16'h0401,SP_AMB},{16'h0410,16'h044F,SP_AMB},{16'h0451,16'h0451,SP_AMB},
    {16'h1100,16'h115F,SP_TWO},{16'h2010,16'h2010,SP_AMB},{16'h2013,16'h2016,SP_AMB},
    {16'h2018,16'h2019,SP_AMB},{16'h201C,16'h201D,SP_AMB},{16'h2020,16'h2021,SP_AMB},
    {16'h2025,16'h2027,SP_AMB},{16'h2030,16'h2030,SP_AMB},{16'h2032,16'h2033,SP_AMB},
    {16'h2035,16'h2035,SP_AMB},{16'h203B,16'h203B,SP_AMB},{16'h2074,16'h2074,SP_AMB},
    {16'h207F,16'h207F,SP_AMB},{16'h2081,16'h2084,SP_AMB},{16'h20A9,16'h20A9,SP_ONE},
    {16'h20AC,16'h20AC,SP_AMB},{16'h2103,16'h2103,SP_AMB},{16'h2105,16'h2105,SP_AMB},
    {16'h2109,16'h2109,SP_AMB},{16'h2113,16'h2113,SP_AMB},{16'h2121,16'h2122,SP_AMB},
    {16'h2126,16'h2126,SP_AMB},{16'h212B,16'h212B,SP_AMB},{16'h2154,16'h2155,SP_AMB},
    {16'h215B,16'h215B,SP_AMB},{16'h215E,16'h215E,SP_AMB},{16'h2160,16'h216B,SP_AMB},
    {16'h2170,16'h2179,SP_AMB},{16'h2190,16'h2199,SP_AMB},{16'h21D2,16'h21D2,SP_AMB},
    {16'h21D4,16'h21D4,SP_AMB},{16'h2200,16'h2200,SP_AMB},{16'h2202,16'h2203,SP_AMB},
    {16'h2207,16'h2208,SP_AMB},{16'h220B,16'h220B,SP_AMB},{16'h220F,16'h220F,SP_AMB},
    {16'h2211,16'h2211,SP_AMB},{16'h2215,16'h2215,SP_AMB},{16'h221A,16'h221A,SP_AMB},
    {16'h221D,16'h2220,SP_AMB},{16'h2223,16'h2223,SP_AMB},{16'h2225,16'h2225,SP_AMB},
    {16'h2227,16'h222C,SP_AMB},{16'h222E,16'h222E,SP_AMB},{16'h2234,16'h2237,SP_AMB},
    {16'h223C,16'h223D,SP_AMB},{16'h2248,16'h2248,SP_AMB},{16'h224C,16'h224C,SP_AMB},
    {16'h2252,16'h2252,SP_AMB},{16'h2260,16'h2261,SP_AMB},{16'h2264,16'h2267,SP_AMB},
    {16'h226A,16'h226B,SP_AMB},{16'h226E,16'h226F,SP_AMB},{16'h2282,16'h2283,SP_AMB},
    {16'h2286,16'h2287,SP_AMB},{16'h2295,16'h2295,SP_AMB},{16'h2299,16'h2299,SP_AMB},
    {16'h22A5,16'h22A5,SP_AMB},{16'h22BF,16'h22BF,SP_AMB},{16'h2312,16'h2312,SP_AMB},
    {16'h2460,16'h24BF,SP_AMB},{16'h24D0,16'h24E9,SP_AMB},{16'h2500,16'h254B,SP_AMB},
    {16'h2550,16'h2574,SP_AMB},{16'h2580,16'h258F,SP_AMB},{16'h2592,16'h25A1,SP_AMB},
    {16'h25A3,16'h25A9,SP_AMB},{16'h25B2,16'h25B3,SP_AMB},{16'h25B6,16'h25B7,SP_AMB},
    {16'h25BC,16'h25BD,SP_AMB},{16'h25C0,16'h25C1,SP_AMB},{16'h25C6,16'h25C8,SP_AMB},
    {16'h25CB,16'h25CB,SP_AMB},{16'h25CE,16'h25D1,SP_AMB},{16'h25E2,16'h25E5,SP_AMB},
    {16'h25EF,16'h25EF,SP_AMB},{16'h2605,16'h2606,SP_AMB},{16'h2609,16'h2609,SP_AMB},
    {16'h260E,16'h260F,SP_AMB},{16'h261C,16'h261C,SP_AMB},{16'h261E,16'h261E,SP_AMB},
    {16'h2640,16'h2640,SP_AMB},{16'h2642,16'h2642,SP_AMB},{16'h2660,16'h2661,SP_AMB},
    {16'h2663,16'h2665,SP_AMB},{16'h2667,16'h266A,SP_AMB},{16'h266C,16'h266D,SP_AMB},
    {16'h266F,16'h266F,SP_AMB},{16'h2E80,16'h3009,SP_TWO},{16'h300A,16'h300B,SP_AMB},
    {16'h300C,16'h3019,SP_TWO},{16'h301A,16'h301B,SP_AMB},{16'h301C,16'h303E,SP_TWO},
    {16'h3041,16'hD7A3,SP_TWO},{16'hE000,16'hF8FF,SP_AMB},{16'hF900,16'hFA2D,SP_TWO},
    {16'hFE30,16'hFE6B,SP_TWO},{16'hFF01,16'hFF5E,SP_TWO},{16'hFF61,16'hFFDC,SP_ONE},
    {16'hFFE0,16'hFFE6,SP_TWO},{16'hFFE8,16'hFFEE,SP_ONE}
  };

endpackage

[src/east_asian_char_width_column.sv]
// channel  direction  payload        handshake
// in       input      in_item_t      in_valid / in_ready
// out      output     out_item_t     out_valid / out_ready
// cfg      input      index, data    cfg_valid / cfg_ready
// one item per cycle sustained unless the output stalls, except a dynamic tab with
// nonzero tab size: the back holds it, finding the remainder one bit per cycle.
// a result passes the classifier register, the two-entry queue and the result
// register; such a tab also waits in the remainder sequencer of the back.
// synchronous active-low reset clears control, registers go to 0 / 1 / 8.
// either side may stall; the queue lets the classifier run ahead of the back.
module east_asian_char_width_column import eacw_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CfgIdxBits-1:0] cfg_index,
  input  logic [6:0]            cfg_data
);

  logic       cjk_r, dyn_r;
  logic [6:0] ts_r;
  logic       fr_valid, fr_ready, bk_valid, bk_ready;
  cls_item_t  fr_item, bk_item;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cjk_r <= 1'b0;
      dyn_r <= 1'b1;
      ts_r  <= 7'd8;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_CJK_AMB:  cjk_r <= cfg_data[0];
        CFG_TAB_DYN:  dyn_r <= cfg_data[0];
        CFG_TAB_SIZE: ts_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  eacw_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .fr_valid, .fr_ready, .fr_item
  );

  eacw_fifo u_fifo (
    .clk, .rst_n, .wr_valid(fr_valid), .wr_ready(fr_ready), .wr_item(fr_item),
    .rd_valid(bk_valid), .rd_ready(bk_ready), .rd_item(bk_item)
  );

  eacw_back u_back (
    .clk, .rst_n, .bk_valid, .bk_ready, .bk_item,
    .cjk_amb(cjk_r), .tab_dyn(dyn_r), .tab_size(ts_r),
    .out_valid, .out_ready, .out_data
  );

endmodule

[src/eacw_front.sv]
module eacw_front import eacw_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      fr_valid,
  input  logic      fr_ready,
  output cls_item_t fr_item
);

  logic      vld_r;
  cls_item_t item_r;
  logic [1:0] span_cls;
  cls_t      cls_nxt;
  logic [15:0] cp16;

  assign cp16 = in_data.code_point[15:0];

  // spans are disjoint, so an or over all hits gives the single match
  always_comb begin
    span_cls = SP_NONE;
    for (int i = 0; i < NumSpans; i++) begin
      if (cp16 >= SPANS[i][33:18] && cp16 <= SPANS[i][17:2]) begin
        span_cls = SPANS[i][1:0];
      end
    end
  end

  // class of the code point
  always_comb begin
    if (in_data.code_point > 21'h00FFFF) begin
      if (in_data.code_point >= 21'h020000 && in_data.code_point <= 21'h02FFFD) begin
        cls_nxt = CLS_TWO;
      end else begin
        cls_nxt = CLS_AMB;
      end
    end else if (cp16 == 16'hFFFE || cp16 == 16'hFFFF) begin
      cls_nxt = CLS_BAD;
    end else begin
      case (span_cls)
        SP_ONE:  cls_nxt = CLS_ONE;
        SP_TWO:  cls_nxt = CLS_TWO;
        SP_AMB:  cls_nxt = CLS_AMB;
        default: begin
          if (cp16 == 16'h0000 || cp16 == 16'h0007 || cp16 == 16'h001B
              || cp16 == 16'hFEFF) begin
            cls_nxt = CLS_ZERO;
          end else if (cp16 == 16'h0008) begin
            cls_nxt = CLS_BS;
          end else if (cp16 == 16'h0009) begin
            cls_nxt = CLS_TAB;
          end else begin
            cls_nxt = CLS_ONE;
          end
        end
      endcase
    end
  end

  assign in_ready = !vld_r || fr_ready;
  assign fr_valid = vld_r;
  assign fr_item  = item_r;

  // output register of the classifier
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ready) begin
      vld_r <= in_valid;
    end
    if (in_valid && in_ready) begin
      item_r <= '{cls: cls_nxt, first: in_data.first_of_string,
                  start_column: in_data.start_column, last: in_data.last_of_string};
    end
  end

endmodule

[src/eacw_fifo.sv]
module eacw_fifo import eacw_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      wr_valid,
  output logic      wr_ready,
  input  cls_item_t wr_item,
  output logic      rd_valid,
  input  logic      rd_ready,
  output cls_item_t rd_item
);

  cls_item_t mem_r [2];
  logic      wp_r, rp_r;
  logic [1:0] cnt_r;

  assign wr_ready = cnt_r != 2'd2;
  assign rd_valid = cnt_r != 2'd0;
  assign rd_item  = mem_r[rp_r];

  // two-entry queue between front and back
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr_valid && wr_ready) wp_r <= !wp_r;
      if (rd_valid && rd_ready) rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(wr_valid && wr_ready) - 2'(rd_valid && rd_ready);
    end
    if (wr_valid && wr_ready) mem_r[wp_r] <= wr_item;
  end

endmodule

[src/eacw_back.sv]
module eacw_back import eacw_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      bk_valid,
  output logic      bk_ready,
  input  cls_item_t bk_item,
  input  logic      cjk_amb,
  input  logic      tab_dyn,
  input  logic [6:0] tab_size,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int CB = ColumnBits;
  localparam int BitW = $clog2(CB);
  localparam logic signed [CB+1:0] ColMax = (CB+2)'((64'sd1 <<< (CB-1)) - 1);
  localparam logic signed [CB+1:0] ColMin = -ColMax - 1;

  typedef enum logic [1:0] {ST_IDLE, ST_MOD, ST_DONE} state_t;

  logic signed [CB-1:0] col_r, sum_r;
  logic                 vld_r;
  out_item_t            out_r;
  state_t               state_r;
  logic [6:0]           rem_r;
  logic [BitW-1:0]      bit_r;

  logic signed [CB-1:0] col_base, sum_base, col_nxt, sum_nxt;
  logic [6:0]           ts, rem_nxt;
  logic [7:0]           rem_try;
  logic                 need_mod, out_free;
  logic signed [7:0]    w;
  logic signed [CB+1:0] col_ext, sum_ext;

  // saturated start column (column width equals field width here)
  assign col_base = bk_item.first ? CB'(bk_item.start_column) : col_r;
  assign sum_base = bk_item.first ? '0 : sum_r;
  assign ts = (tab_size > 7'd64) ? 7'd64 : tab_size;
  assign need_mod = bk_valid && (bk_item.cls == CLS_TAB) && tab_dyn && (ts != 7'd0);

  // floor modulo of the column by the tab size, one bit per cycle, msb first
  assign rem_try = {rem_r, col_base[bit_r]};
  assign rem_nxt = (rem_try >= {1'b0, ts}) ? 7'(rem_try - {1'b0, ts}) : 7'(rem_try);

  // width from class
  always_comb begin
    case (bk_item.cls)
      CLS_ONE:  w = 8'sd1;
      CLS_TWO:  w = 8'sd2;
      CLS_AMB:  w = cjk_amb ? 8'sd2 : 8'sd1;
      CLS_BS:   w = -8'sd1;
      CLS_TAB:  begin
        if (ts == 7'd0) w = 8'sd0;
        else if (!tab_dyn) w = 8'(ts);
        else w = 8'(ts - rem_r);
      end
      default:  w = 8'sd0;
    endcase
  end

  always_comb begin
    col_ext = (CB+2)'(col_base) + (CB+2)'(w);
    sum_ext = (CB+2)'(sum_base) + (CB+2)'(w);
    if (col_ext > ColMax) col_nxt = CB'(ColMax);
    else if (col_ext < ColMin) col_nxt = CB'(ColMin);
    else col_nxt = CB'(col_ext);
    if (sum_ext > ColMax) sum_nxt = CB'(ColMax);
    else if (sum_ext < ColMin) sum_nxt = CB'(ColMin);
    else sum_nxt = CB'(sum_ext);
  end

  assign out_free  = !vld_r || out_ready;
  assign bk_ready  = out_free && ((state_r == ST_DONE) || (state_r == ST_IDLE && !need_mod));
  assign out_valid = vld_r;
  assign out_data  = out_r;

  // running column, sum, remainder sequencer and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= 1'b0;
      col_r   <= '0;
      sum_r   <= '0;
      state_r <= ST_IDLE;
      rem_r   <= '0;
      bit_r   <= '0;
    end else begin
      if (out_free) vld_r <= bk_valid && bk_ready;
      if (bk_valid && bk_ready) begin
        col_r <= col_nxt;
        sum_r <= sum_nxt;
      end
      case (state_r)
        ST_IDLE: begin
          if (need_mod) begin
            // a set sign bit starts the remainder at ts - 1, that is -1 mod ts
            rem_r   <= col_base[CB-1] ? (ts - 7'd1) : 7'd0;
            bit_r   <= BitW'(CB-2);
            state_r <= ST_MOD;
          end
        end
        ST_MOD: begin
          rem_r <= rem_nxt;
          if (bit_r == '0) state_r <= ST_DONE;
          else bit_r <= bit_r - BitW'(1);
        end
        ST_DONE: begin
          if (bk_valid && bk_ready) state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
    if (bk_valid && bk_ready) begin
      out_r <= '{char_width: w, cursor_column: 16'(col_nxt),
                 string_width: 16'(sum_nxt), invalid_char: bk_item.cls == CLS_BAD,
                 end_of_string: bk_item.last};
    end
  end

endmodule

[sim/east_asian_char_width_column_test.sv]
module east_asian_char_width_column_test;
  import eacw_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int IdleLimit = 20000;
  localparam int ColMax = 32767;
  localparam int ColMin = -32768;

  // width classes of the shadow classifier
  typedef enum int {WC_ONE, WC_TWO, WC_AMB, WC_NEUTRAL} width_class_e;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_item_t in_data;
  logic out_valid;
  logic out_ready;
  out_item_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [CfgIdxBits-1:0] cfg_index;
  logic [6:0] cfg_data;

  east_asian_char_width_column dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // shadow registers and running state
  logic amb_wide;
  logic tab_dyn;
  logic [6:0] tab_stop;
  int column_now;
  int width_sum;
  out_item_t width_queue[$];

  int send_idle_pct;
  int recv_idle_pct;
  int fail_count;
  int idle_cycles;

  // clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // range table lookup
  function automatic width_class_e class_of(logic [20:0] cp);
    logic [33:0] span;
    if (cp > 21'h00FFFF) begin
      if (cp >= 21'h020000 && cp <= 21'h02FFFD) return WC_TWO;
      return WC_AMB;
    end
    for (int i = 0; i < NumSpans; i++) begin
      span = SPANS[i];
      if (cp[15:0] >= span[33:18] && cp[15:0] <= span[17:2]) begin
        case (span[1:0])
          SP_ONE: return WC_ONE;
          SP_TWO: return WC_TWO;
          default: return WC_AMB;
        endcase
      end
    end
    return WC_NEUTRAL;
  endfunction

  function automatic int clamp_column(int v);
    if (v > ColMax) return ColMax;
    if (v < ColMin) return ColMin;
    return v;
  endfunction

  // columns one code point advances at the given column
  function automatic int columns_of(logic [20:0] cp, int col);
    int ts;
    int m;
    ts = (tab_stop > 7'd64) ? 64 : int'(tab_stop);
    case (class_of(cp))
      WC_ONE: return 1;
      WC_TWO: return 2;
      WC_AMB: return amb_wide ? 2 : 1;
      default: ;
    endcase
    if (cp == 21'h0 || cp == 21'h7 || cp == 21'h1B || cp == 21'hFEFF) return 0;
    if (cp == 21'h8) return -1;
    if (cp == 21'h9) begin
      if (ts == 0) return 0;
      if (!tab_dyn) return ts;
      m = col % ts;
      if (m < 0) m += ts;
      return ts - m;
    end
    return 1;
  endfunction

  // advance the shadow state and queue the expected result
  function automatic void predict_width(in_item_t it);
    out_item_t r;
    logic bad;
    int w;
    bad = (it.code_point == 21'hFFFE || it.code_point == 21'hFFFF);
    w = 0;
    if (it.first_of_string) begin
      column_now = int'(it.start_column);
      width_sum = 0;
    end
    if (!bad) begin
      w = columns_of(it.code_point, column_now);
      column_now = clamp_column(column_now + w);
      width_sum = clamp_column(width_sum + w);
    end
    r.char_width = w[7:0];
    r.cursor_column = column_now[15:0];
    r.string_width = width_sum[15:0];
    r.invalid_char = bad;
    r.end_of_string = it.last_of_string;
    width_queue.push_back(r);
  endfunction

  // send one character transaction; valid drops only when the sender idles
  task automatic send_char(logic [20:0] cp, logic first, logic signed [15:0] sc,
                           logic last);
    in_item_t it;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    it.code_point = cp;
    it.first_of_string = first;
    it.start_column = sc;
    it.last_of_string = last;
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_width(it);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (width_queue.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // register write, only while idle
  task automatic write_reg(logic [CfgIdxBits-1:0] idx, logic [6:0] val);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_CJK_AMB: amb_wide = val[0];
      CFG_TAB_DYN: tab_dyn = val[0];
      default: tab_stop = val;
    endcase
  endtask

  // receiver stall and result check
  always @(posedge clk) begin
    out_item_t exp_r;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
      if (out_valid && out_ready) begin
        if (width_queue.size() == 0) begin
          $error("unexpected result %h", out_data);
          fail_count++;
        end else begin
          exp_r = width_queue.pop_front();
          if (out_data.char_width !== exp_r.char_width) begin
            $error("char_width exp %0d got %0d", exp_r.char_width, out_data.char_width);
            fail_count++;
          end
          if (out_data.cursor_column !== exp_r.cursor_column) begin
            $error("cursor_column exp %0d got %0d", exp_r.cursor_column,
                   out_data.cursor_column);
            fail_count++;
          end
          if (out_data.string_width !== exp_r.string_width) begin
            $error("string_width exp %0d got %0d", exp_r.string_width,
                   out_data.string_width);
            fail_count++;
          end
          if (out_data.invalid_char !== exp_r.invalid_char) begin
            $error("invalid_char exp %0b got %0b", exp_r.invalid_char,
                   out_data.invalid_char);
            fail_count++;
          end
          if (out_data.end_of_string !== exp_r.end_of_string) begin
            $error("end_of_string exp %0b got %0b", exp_r.end_of_string,
                   out_data.end_of_string);
            fail_count++;
          end
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)
        || !rst_n) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("east_asian_char_width_column test failed");
        $finish;
      end
    end
  end

  // a random code point, biased toward interesting regions
  function automatic logic [20:0] pick_code_point();
    case ($urandom_range(9))
      0: return 21'($urandom_range(31));
      1: return 21'($urandom_range(32'h20, 32'h7E));
      2: return 21'($urandom_range(32'hA0, 32'h4FF));
      3: return 21'($urandom_range(32'h1100, 32'h3100));
      4: return 21'($urandom_range(32'h3041, 32'hFFFF));
      5: return 21'($urandom_range(32'hFFF0, 32'hFFFF));
      6: return 21'($urandom_range(32'h10000, 32'h30000));
      7: return 21'($urandom_range(32'h1FFFFF));
      8: return 21'h9;
      default: return 21'($urandom_range(32'h2000, 32'h2700));
    endcase
  endfunction

  // random strings with random start columns
  task automatic run_random_strings(int n);
    int left;
    int len;
    logic signed [15:0] sc;
    left = n;
    while (left > 0) begin
      len = $urandom_range(1, 12);
      case ($urandom_range(3))
        0: sc = 16'($urandom);
        1: sc = 16'($urandom_range(ColMax - 20, ColMax));
        2: sc = 16'(-$urandom_range(0, 20));
        default: sc = 16'($urandom_range(0, 200));
      endcase
      if ($urandom_range(9) == 0) sc = 16'sh8000;
      for (int i = 0; i < len && left > 0; i++) begin
        send_char(pick_code_point(), (i == 0) || ($urandom_range(19) == 0), sc,
                  (i == len - 1) || ($urandom_range(19) == 0));
        left--;
      end
    end
  endtask

  task automatic test_reset_defaults();
    send_char(21'h9, 1'b1, 16'sd3, 1'b0);
    send_char(21'h41, 1'b0, 16'sd0, 1'b0);
    send_char(21'h00A1, 1'b0, 16'sd0, 1'b1);
  endtask

  task automatic test_directed_classes();
    send_char(21'h0, 1'b1, 16'sd0, 1'b0);
    send_char(21'h7, 1'b0, 16'sd0, 1'b0);
    send_char(21'h1B, 1'b0, 16'sd0, 1'b0);
    send_char(21'hFEFF, 1'b0, 16'sd0, 1'b0);
    send_char(21'h8, 1'b0, 16'sd0, 1'b0);
    send_char(21'h8, 1'b0, 16'sd0, 1'b0);
    send_char(21'hFFFE, 1'b0, 16'sd0, 1'b0);
    send_char(21'hFFFF, 1'b0, 16'sd0, 1'b0);
    send_char(21'h4E00, 1'b0, 16'sd0, 1'b0);
    send_char(21'h20000, 1'b0, 16'sd0, 1'b0);
    send_char(21'h2FFFE, 1'b0, 16'sd0, 1'b0);
    send_char(21'h1FFFFF, 1'b0, 16'sd0, 1'b0);
    send_char(21'hFF61, 1'b0, 16'sd0, 1'b1);
    // negative column tab and saturation at both ends
    send_char(21'h9, 1'b1, -16'sd3, 1'b1);
    send_char(21'h4E00, 1'b1, 16'sh7FFF, 1'b0);
    send_char(21'h9, 1'b0, 16'sd0, 1'b1);
    send_char(21'h8, 1'b1, 16'sh8000, 1'b1);
    send_char(21'h41, 1'b0, 16'sd0, 1'b0);
  endtask

  task automatic test_tab_settings();
    write_reg(CFG_CJK_AMB, 7'd1);
    write_reg(CFG_TAB_DYN, 7'd0);
    write_reg(CFG_TAB_SIZE, 7'd127);
    send_char(21'h9, 1'b1, 16'sd5, 1'b0);
    send_char(21'h00A1, 1'b0, 16'sd0, 1'b1);
    write_reg(CFG_TAB_SIZE, 7'd0);
    send_char(21'h9, 1'b1, 16'sd5, 1'b1);
    write_reg(CFG_TAB_DYN, 7'd1);
    write_reg(CFG_TAB_SIZE, 7'd64);
    send_char(21'h9, 1'b1, -16'sd100, 1'b1);
  endtask

  task automatic test_random_phase(int sidle, int ridle);
    send_idle_pct = sidle;
    recv_idle_pct = ridle;
    for (int k = 0; k < 4; k++) begin
      wait_drained();
      write_reg(CFG_CJK_AMB, 7'($urandom_range(1)));
      write_reg(CFG_TAB_DYN, 7'($urandom_range(1)));
      write_reg(CFG_TAB_SIZE, 7'($urandom_range(127)));
      run_random_strings(140);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    amb_wide = 1'b0;
    tab_dyn = 1'b1;
    tab_stop = 7'd8;
    column_now = 0;
    width_sum = 0;
    fail_count = 0;
    send_idle_pct = 38;
    recv_idle_pct = 85;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_directed_classes();
    test_tab_settings();
    test_random_phase(38, 85);
    test_random_phase(85, 38);
    test_random_phase(0, 0);

    wait_drained();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("east_asian_char_width_column test passed");
    end else begin
      $display("east_asian_char_width_column test failed");
    end
    $finish;
  end

endmodule
